// File: design/rpms_pkg.sv
// rpms_pkg: shared types, constants and tables for the rectangle patrol
// motor sequencer. No dependencies.

package rpms_pkg;

  // Pulse counter width
  localparam int COUNT_W = 8;
  // Lengths are 8-bit registers; compares run at the wider of the two
  localparam int LEN_W   = 8;
  localparam int CMP_W   = (COUNT_W > LEN_W) ? COUNT_W : LEN_W;

  localparam int IN_DATA_W  = 16;  // 14 payload bits, byte padded
  localparam int OUT_DATA_W = 16;  // 11 payload bits, byte padded
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_FOUR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACK        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RUN        = 3'd6;

  // Register reset values
  localparam logic [LEN_W-1:0] TURN_PULSES_RST = 8'd6;
  localparam logic [7:0]       ACK_CODE_RST    = 8'd9;

  // Motor line patterns: bit0 m11, bit1 m12, bit2 m21, bit3 m22
  localparam logic [3:0] DRIVE_PATTERN = 4'h9;
  localparam logic [3:0] TURN_PATTERN  = 4'h1;
  localparam logic [3:0] MOTORS_OFF    = 4'h0;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_SCAN  = 2'd1,
    MODE_ACK   = 2'd2,
    MODE_CLEAR = 2'd3
  } obs_mode_t;

  // Sensor slots, served in this order
  localparam logic [1:0] SLOT_LEFT  = 2'd0;
  localparam logic [1:0] SLOT_RIGHT = 2'd1;
  localparam logic [1:0] SLOT_FRONT = 2'd2;
  localparam logic [1:0] SLOT_BACK  = 2'd3;

  // Obstacle codes sent on the serial link
  localparam logic [1:0] CODE_LEFT  = 2'd3;
  localparam logic [1:0] CODE_RIGHT = 2'd1;
  localparam logic [1:0] CODE_FRONT = 2'd0;
  localparam logic [1:0] CODE_BACK  = 2'd2;

  function automatic logic [1:0] slot_code(input logic [1:0] slot);
    logic [1:0] code;
    unique case (slot)
      SLOT_LEFT:  code = CODE_LEFT;
      SLOT_RIGHT: code = CODE_RIGHT;
      SLOT_FRONT: code = CODE_FRONT;
      default:    code = CODE_BACK;
    endcase
    return code;
  endfunction

endpackage

// File: design/rectangle_patrol_motor_sequencer.sv
// rectangle_patrol_motor_sequencer: top level, eight-phase patrol sequencer
// with obstacle reporting. Depends on rpms_pkg.
//
//  channel  | direction | payload, lowest bit first
//  ---------+-----------+-------------------------------------------------------
//  in_      | slave     | pulse, sensor_levels[4], rx_valid, rx_byte[8]
//  out_     | master    | motor_drive[4], tx_valid, tx_code[2], phase[3], obstacle_busy
//  cfg_     | write     | index 0..6: side lengths 1..4, turn_pulses, ack_code, run_enable
//
// One item per clock unless out_ stalls: the phase/obstacle state and the result
// register both load at the accepting edge, so the result is offered on out_
// the next cycle. in_tready is high while the output register is empty or being
// drained, so a stalled consumer holds off input only once a result is waiting.
// Reset (rst_n low, synchronous) clears the state, the output valid and sets the
// registers to their reset values (turn_pulses 6, ack_code 9, others 0).

module rectangle_patrol_motor_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  // pulse, sensor_levels[3:0], rx_valid, rx_byte[7:0], zero pad
  input  logic [rpms_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // motor_drive[3:0], tx_valid, tx_code[1:0], phase[2:0], obstacle_busy, pad
  output logic [rpms_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [rpms_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [rpms_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import rpms_pkg::*;

  // configuration
  logic [LEN_W-1:0] side_one_r, side_two_r, side_three_r, side_four_r, turn_r;
  logic [7:0]       ack_r;
  logic             run_en_r;

  // sequencer state
  logic [2:0]         phase_r, phase_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  obs_mode_t          mode_r, mode_nxt;
  logic [1:0]         slot_r, slot_nxt;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // input fields
  logic       in_pulse;
  logic [3:0] in_sens;
  logic       in_rx_valid;
  logic [7:0] in_rx_byte;

  logic       in_acc;

  // result fields
  logic [3:0] motors;
  logic       tx_valid;
  logic [1:0] tx_code;

  // scratch
  logic             drive;
  logic [COUNT_W-1:0] cnt_inc;
  logic [LEN_W-1:0] limit;

  assign in_pulse    = in_tdata[0];
  assign in_sens     = in_tdata[4:1];
  assign in_rx_valid = in_tdata[5];
  assign in_rx_byte  = in_tdata[13:6];

  // Output register doubles as the skid stage between the two sides
  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration writes; out-of-range index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_one_r   <= '0;
      side_two_r   <= '0;
      side_three_r <= '0;
      side_four_r  <= '0;
      turn_r       <= TURN_PULSES_RST;
      ack_r        <= ACK_CODE_RST;
      run_en_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SIDE_ONE:   side_one_r   <= cfg_wdata[LEN_W-1:0];
        REG_SIDE_TWO:   side_two_r   <= cfg_wdata[LEN_W-1:0];
        REG_SIDE_THREE: side_three_r <= cfg_wdata[LEN_W-1:0];
        REG_SIDE_FOUR:  side_four_r  <= cfg_wdata[LEN_W-1:0];
        REG_TURN:       turn_r       <= cfg_wdata[LEN_W-1:0];
        REG_ACK:        ack_r        <= cfg_wdata[7:0];
        REG_RUN:        run_en_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Next state and result for the item on the input
  always_comb begin
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    slot_nxt  = slot_r;
    motors    = MOTORS_OFF;
    tx_valid  = 1'b0;
    tx_code   = 2'd0;
    drive     = !phase_r[0];
    cnt_inc   = cnt_r + COUNT_W'(in_pulse);
    cnt_nxt   = cnt_inc;
    limit     = turn_r;

    if (!run_en_r) begin
      // disabled: hold everything at reset, motors off
      phase_nxt = 3'd0;
      cnt_nxt   = '0;
      mode_nxt  = MODE_IDLE;
      slot_nxt  = SLOT_LEFT;
    end else begin
      // obstacle entry, then scan of slot 0 in the same item
      if (drive && mode_r == MODE_IDLE && in_sens != 4'd0) begin
        mode_nxt = MODE_SCAN;
        slot_nxt = SLOT_LEFT;
      end

      unique case (mode_nxt)
        MODE_SCAN: begin
          if (in_sens[slot_nxt]) begin
            tx_valid = 1'b1;
            tx_code  = slot_code(slot_nxt);
            mode_nxt = MODE_ACK;
          end else if (slot_nxt == SLOT_BACK) begin
            slot_nxt = SLOT_LEFT;
            mode_nxt = MODE_IDLE;
          end else begin
            slot_nxt = slot_nxt + 2'd1;
          end
        end
        MODE_ACK: begin
          if (in_rx_valid && in_rx_byte == ack_r) mode_nxt = MODE_CLEAR;
        end
        MODE_CLEAR: begin
          if (!in_sens[slot_nxt]) begin
            if (slot_nxt == SLOT_BACK) begin
              slot_nxt = SLOT_LEFT;
              mode_nxt = MODE_IDLE;
            end else begin
              slot_nxt = slot_nxt + 2'd1;
              mode_nxt = MODE_SCAN;
            end
          end
        end
        default: ;
      endcase

      // phase end only when no report is pending
      if (mode_nxt == MODE_IDLE) begin
        if (drive) begin
          unique case (phase_r[2:1])
            2'd0:    limit = side_one_r;
            2'd1:    limit = side_two_r;
            2'd2:    limit = side_three_r;
            default: limit = side_four_r;
          endcase
        end
        if (CMP_W'(cnt_inc) >= CMP_W'(limit)) begin
          phase_nxt = phase_r + 3'd1;
          cnt_nxt   = '0;
        end else begin
          motors = drive ? DRIVE_PATTERN : TURN_PATTERN;
        end
      end
    end

    out_data_nxt = {5'd0, (mode_nxt != MODE_IDLE), phase_nxt, tx_code, tx_valid, motors};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 3'd0;
      cnt_r       <= '0;
      mode_r      <= MODE_IDLE;
      slot_r      <= SLOT_LEFT;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        mode_r  <= mode_nxt;
        slot_r  <= slot_nxt;
      end
      if (in_acc)          out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) out_data_r <= out_data_nxt;
  end

  // A sent code always leaves the block waiting for the ack
  a_tx_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[4] |-> out_data_r[10])
    else $error("tx without obstacle busy");

  // Motors are off while a report is handled
  a_busy_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[10] |-> out_data_r[3:0] == MOTORS_OFF)
    else $error("motors running during obstacle handling");

  // Obstacle handling only ever happens in a drive phase
  a_mode_drive: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_IDLE |-> !phase_r[0])
    else $error("obstacle handling in a turn phase");

  // An item taken while disabled leaves the state at reset
  a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !run_en_r |=> phase_r == 3'd0 && mode_r == MODE_IDLE && cnt_r == '0)
    else $error("state not cleared while disabled");

  // Reported phase matches the state left by the item that made it
  a_phase_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_data_r[9:7] == phase_r)
    else $error("result phase differs from state");

endmodule

// File: tb/rectangle_patrol_motor_sequencer_checker.sv
// Checker for the rectangle patrol motor sequencer: watches the in_, out_ and cfg_
// ports, predicts each result from its own copy of the patrol state and compares.
// Depends on rpms_pkg.

module rectangle_patrol_motor_sequencer_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [rpms_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [rpms_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [rpms_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rpms_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending,
  output int                              checked
);
  import rpms_pkg::*;

  typedef struct packed {
    logic [3:0] motors;
    logic       tx_valid;
    logic [1:0] tx_code;
    logic [2:0] phase;
    logic       busy;
  } patrol_result_t;

  // register copy
  logic [7:0] side_one, side_two, side_three, side_four;
  logic [7:0] turn_len, ack_byte;
  logic       run_en;

  // patrol state copy
  logic [2:0]         leg_phase;
  logic [COUNT_W-1:0] odo_count;
  obs_mode_t          mode;
  logic [1:0]         slot;

  patrol_result_t expected_results[$];
  int             fails;
  int             seen;

  initial begin
    fails      = 0;
    seen       = 0;
  end

  function automatic void step_slot();
    if (slot == SLOT_BACK) begin
      slot = SLOT_LEFT;
      mode = MODE_IDLE;
    end else begin
      slot = slot + 2'd1;
      mode = MODE_SCAN;
    end
  endfunction

  function automatic patrol_result_t advance_patrol(input logic       pulse,
                                                    input logic [3:0] sensors,
                                                    input logic       rx_valid,
                                                    input logic [7:0] rx_byte);
    patrol_result_t res;
    logic           driving;
    logic [7:0]     limit;
    res = '0;
    if (!run_en) begin
      leg_phase = '0;
      odo_count = '0;
      mode      = MODE_IDLE;
      slot      = SLOT_LEFT;
    end else begin
      driving   = ~leg_phase[0];
      odo_count = odo_count + COUNT_W'(pulse);
      // obstacles only interrupt drive legs; turns ignore the sensors
      if (driving && mode == MODE_IDLE && sensors != 4'd0) begin
        mode = MODE_SCAN;
        slot = SLOT_LEFT;
      end
      case (mode)
        MODE_SCAN: begin
          if (sensors[slot]) begin
            res.tx_valid = 1'b1;
            case (slot)
              SLOT_LEFT:  res.tx_code = CODE_LEFT;
              SLOT_RIGHT: res.tx_code = CODE_RIGHT;
              SLOT_FRONT: res.tx_code = CODE_FRONT;
              default:    res.tx_code = CODE_BACK;
            endcase
            mode = MODE_ACK;
          end else begin
            step_slot();
          end
        end
        MODE_ACK: begin
          if (rx_valid && rx_byte == ack_byte) mode = MODE_CLEAR;
        end
        MODE_CLEAR: begin
          if (!sensors[slot]) step_slot();
        end
        default: ;
      endcase
      if (mode == MODE_IDLE) begin
        if (driving) begin
          case (leg_phase[2:1])
            2'd0:    limit = side_one;
            2'd1:    limit = side_two;
            2'd2:    limit = side_three;
            default: limit = side_four;
          endcase
        end else begin
          limit = turn_len;
        end
        if (int'(odo_count) >= int'(limit)) begin
          leg_phase = leg_phase + 3'd1;
          odo_count = '0;
        end else begin
          res.motors = driving ? DRIVE_PATTERN : TURN_PATTERN;
        end
      end
    end
    res.phase = leg_phase;
    res.busy  = (mode != MODE_IDLE);
    return res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    patrol_result_t want;
    if (!rst_n) begin
      side_one   = '0;
      side_two   = '0;
      side_three = '0;
      side_four  = '0;
      turn_len   = TURN_PULSES_RST;
      ack_byte   = ACK_CODE_RST;
      run_en     = 1'b0;
      leg_phase  = '0;
      odo_count  = '0;
      mode       = MODE_IDLE;
      slot       = SLOT_LEFT;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result %h arrived with no item outstanding", out_tdata);
          fails++;
        end else begin
          want = expected_results.pop_front();
          check_field("motor_drive",   int'(want.motors),   int'(out_tdata[3:0]));
          check_field("tx_valid",      int'(want.tx_valid), int'(out_tdata[4]));
          check_field("tx_code",       int'(want.tx_code),  int'(out_tdata[6:5]));
          check_field("phase",         int'(want.phase),    int'(out_tdata[9:7]));
          check_field("obstacle_busy", int'(want.busy),     int'(out_tdata[10]));
          seen++;
        end
      end
      // item first: a register written at this edge applies from the next one
      if (in_tvalid && in_tready)
        expected_results.push_back(advance_patrol(in_tdata[0], in_tdata[4:1],
                                                  in_tdata[5], in_tdata[13:6]));
      if (cfg_we) begin
        case (cfg_idx)
          REG_SIDE_ONE:   side_one   = cfg_wdata;
          REG_SIDE_TWO:   side_two   = cfg_wdata;
          REG_SIDE_THREE: side_three = cfg_wdata;
          REG_SIDE_FOUR:  side_four  = cfg_wdata;
          REG_TURN:       turn_len   = cfg_wdata;
          REG_ACK:        ack_byte   = cfg_wdata;
          REG_RUN:        run_en     = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    fail_count <= fails;
    pending    <= expected_results.size();
    checked    <= seen;
  end

endmodule

// File: tb/rectangle_patrol_motor_sequencer_test.sv
// Top of the rectangle patrol motor sequencer bench: clock, reset, register
// programming and item stimulus, plus the verdict. Depends on rpms_pkg, the
// sequencer and rectangle_patrol_motor_sequencer_checker.

module rectangle_patrol_motor_sequencer_test;
  import rpms_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  // pulse, sensor_levels[3:0], rx_valid, rx_byte[7:0], zero pad
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // motor_drive[3:0], tx_valid, tx_code[1:0], phase[2:0], obstacle_busy, pad
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count, pending, checked;

  // idling knobs, percent of cycles
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  int         items_sent = 0;
  int         settings_used = 0;
  logic [7:0] cur_ack = ACK_CODE_RST;
  logic [3:0] held_sensors = '0;   // obstacle levels that persist across items

  always #4 clk = ~clk;

  rectangle_patrol_motor_sequencer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  rectangle_patrol_motor_sequencer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // Result side: random back-pressure at the current stall rate
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Hard stop in case the block hangs
  initial begin
    #(8 * 400000);
    $display("tb: failure");
    $finish;
  end

  // Present one item and hold it until the block takes it. Valid is not
  // dropped between back-to-back items; garbage sits on tdata during gaps.
  task automatic send(input logic pulse, input logic [3:0] sensors,
                      input logic rx_valid, input logic [7:0] rx_byte);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_DATA_W'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, rx_byte, rx_valid, sensors, pulse};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Stop sending and let every outstanding result drain; each item makes one
  // registered result, and the wait runs until the checker has none pending.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  // Rewrite every register while the block is idle; run_enable goes last.
  task automatic write_regs(input logic [7:0] len1, input logic [7:0] len2,
                            input logic [7:0] len3, input logic [7:0] len4,
                            input logic [7:0] turn, input logic [7:0] ack,
                            input logic run);
    logic [7:0] vals [7];
    logic [CFG_IDX_W-1:0] idxs [7];
    drain();
    vals = '{len1, len2, len3, len4, turn, ack, {7'd0, run}};
    idxs = '{REG_SIDE_ONE, REG_SIDE_TWO, REG_SIDE_THREE, REG_SIDE_FOUR,
             REG_TURN, REG_ACK, REG_RUN};
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idxs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    cur_ack  = ack;
    settings_used++;
  endtask

  // Mostly well-formed traffic: obstacles rise and linger, ack bytes come
  // often, pulses run at half rate. A few items are pure noise.
  task automatic random_item();
    logic       rx_valid;
    logic [7:0] rx_byte;
    if ($urandom_range(99) < 6) begin
      send(1'($urandom_range(1)), 4'($urandom_range(15)), 1'($urandom_range(1)),
           8'($urandom_range(255)));
    end else begin
      if ($urandom_range(99) < 10) held_sensors[2'($urandom_range(3))] = 1'b1;
      if ($urandom_range(99) < 25) held_sensors = held_sensors & 4'($urandom_range(15));
      rx_valid = ($urandom_range(99) < 35);
      rx_byte  = ($urandom_range(99) < 65) ? cur_ack : 8'($urandom_range(255));
      send(1'($urandom_range(1)), held_sensors, rx_valid, rx_byte);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed ----
    // after reset run_enable is 0: motors off, state held at reset
    send(1'b1, 4'hF, 1'b1, 8'hFF);
    send(1'b0, 4'h0, 1'b0, 8'h00);

    // unit lengths so each pulse ends a phase
    write_regs(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'hA5, 1'b1);
    send(1'b0, 4'h0, 1'b0, 8'h00);   // leg one drives
    send(1'b1, 4'h0, 1'b0, 8'h00);   // leg ends, motors off this item
    send(1'b0, 4'hF, 1'b1, 8'hA5);   // turn ignores sensors
    send(1'b1, 4'h0, 1'b0, 8'h00);   // into leg two
    // all four sensors: served left, right, front, back
    send(1'b0, 4'hF, 1'b0, 8'h00);   // left reported
    send(1'b1, 4'hF, 1'b1, 8'h5A);   // wrong byte, still waiting for ack
    send(1'b0, 4'hF, 1'b1, 8'hA5);   // acked
    send(1'b0, 4'hF, 1'b0, 8'h00);   // left still blocked
    send(1'b0, 4'hE, 1'b0, 8'h00);   // left clears
    send(1'b0, 4'hE, 1'b0, 8'h00);   // right reported
    send(1'b0, 4'hE, 1'b1, 8'hA5);
    send(1'b0, 4'hC, 1'b0, 8'h00);
    send(1'b0, 4'hC, 1'b0, 8'h00);   // front reported
    send(1'b0, 4'hC, 1'b1, 8'hA5);
    send(1'b0, 4'h8, 1'b0, 8'h00);
    send(1'b0, 4'h8, 1'b0, 8'h00);   // back reported
    send(1'b0, 4'h8, 1'b1, 8'hA5);
    send(1'b0, 4'h0, 1'b0, 8'h00);   // back clears, pending leg end fires
    send(1'b1, 4'h0, 1'b0, 8'h00);   // turn done, leg three
    // only back set: three empty slots scanned first
    send(1'b0, 4'h8, 1'b0, 8'h00);
    send(1'b0, 4'h8, 1'b0, 8'h00);
    send(1'b0, 4'h8, 1'b0, 8'h00);
    send(1'b0, 4'h8, 1'b1, 8'hA5);
    send(1'b0, 4'h0, 1'b0, 8'h00);

    // zero lengths end every phase in its first item; ack byte 0
    write_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    repeat (3) send(1'b0, 4'h0, 1'b1, 8'h00);
    send(1'b0, 4'h1, 1'b0, 8'h00);
    send(1'b0, 4'h1, 1'b1, 8'h00);
    send(1'b1, 4'h0, 1'b0, 8'h00);

    // maximum lengths; a long ack wait lets the pulse counter wrap
    write_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    repeat (270) send(1'b1, 4'h1, 1'b0, 8'h00);
    send(1'b1, 4'h1, 1'b1, 8'hFF);
    send(1'b1, 4'h0, 1'b0, 8'h00);
    repeat (4) send(1'b1, 4'h0, 1'b0, 8'h00);

    // dropping run_enable clears the patrol back to leg one
    write_regs(8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'h33, 1'b0);
    repeat (3) send(1'b1, 4'h5, 1'b1, 8'h33);

    // ---- random: six settings, each through the four idling phases ----
    for (int s = 0; s < 6; s++) begin
      if (s == 5)
        write_regs(8'd255, 8'($urandom_range(6)), 8'd0, 8'($urandom_range(6)),
                   8'($urandom_range(4)), 8'($urandom_range(255)), 1'b1);
      else
        write_regs(8'($urandom_range(6)), 8'($urandom_range(6)), 8'($urandom_range(6)),
                   8'($urandom_range(6)), 8'($urandom_range(4)),
                   8'($urandom_range(255)), 1'b1);
      held_sensors = '0;
      for (int p = 0; p < 4; p++) begin
        case (p)
          0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin sender_idle_pct = 45; recv_stall_pct = 0;  end
          2: begin sender_idle_pct = 0;  recv_stall_pct = 45; end
          default: begin sender_idle_pct = 9; recv_stall_pct = 9; end
        endcase
        repeat (14) random_item();
      end
    end

    // ---- wind down ----
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    drain();
    repeat (5) @(posedge clk);

    $display("tb: %0d items sent, %0d results checked, %0d register settings",
             items_sent, checked, settings_used);
    $display("tb: covered disabled hold, zero and full lengths, counter wrap, all four obstacles");
    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
